[rtl/otle_pkg.sv]
// ----------------------------------------------------------------------------
// otle_pkg
// Shared types and constants for the ordered triple list engine.
// ----------------------------------------------------------------------------
package otle_pkg;

  localparam int DEPTH   = 64;
  localparam int ID_BITS = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int TYPE_W  = 3;
  localparam int STAT_W  = 2;

  localparam logic [TYPE_W-1:0] REQ_INSERT  = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_DELETE  = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_READ    = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_SEARCH  = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_REVERSE = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [ID_BITS-1:0] singer;
    logic [ID_BITS-1:0] album;
    logic [ID_BITS-1:0] song;
  } entry_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  req_type;
    logic [CNT_W-1:0]   position;
    logic [ID_BITS-1:0] singer_id;
    logic [ID_BITS-1:0] album_id;
    logic [ID_BITS-1:0] song_id;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [IDX_W-1:0]   found_index;
    logic [ID_BITS-1:0] out_singer;
    logic [ID_BITS-1:0] out_album;
    logic [ID_BITS-1:0] out_song;
    logic [CNT_W-1:0]   entry_count;
  } rsp_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_SHL  = 2'd1,
    CELL_SHR  = 2'd2
  } cell_mode_t;

  // SHL: cells in [lo, hi) take right neighbor, cell hi takes head.
  // SHR: cells above lo take left neighbor, cell lo takes the new entry.
  typedef struct packed {
    cell_mode_t       mode;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } cell_ctl_t;

endpackage

[rtl/otle_cell.sv]
// ----------------------------------------------------------------------------
// otle_cell
// One list slot: holds one entry and moves it to or from its neighbors.
// ----------------------------------------------------------------------------
module otle_cell
  import otle_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctl_t        ctl,
  input  entry_t           left,
  input  entry_t           right,
  input  entry_t           head,
  input  entry_t           new_entry,
  output entry_t           data
);

  entry_t data_next;

  always_comb begin
    data_next = data;
    case (ctl.mode)
      CELL_SHL: begin
        if (idx >= ctl.lo && idx < ctl.hi) begin
          data_next = right;
        end else if (idx == ctl.hi) begin
          data_next = head;
        end
      end
      CELL_SHR: begin
        if (idx > ctl.lo) begin
          data_next = left;
        end else if (idx == ctl.lo) begin
          data_next = new_entry;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[rtl/otle_ctrl.sv]
// ----------------------------------------------------------------------------
// otle_ctrl
// Request sequencer: checks requests, steers the cell chain, builds results.
// ----------------------------------------------------------------------------
module otle_ctrl
  import otle_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_t      req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_t      rsp,
  input  entry_t    head,
  output entry_t    new_entry,
  output cell_ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_RUN    = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  state_t            state, state_next;
  logic [TYPE_W-1:0] op, op_next;
  logic [CNT_W-1:0]  pos, pos_next;
  entry_t            key, key_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  step, step_next;
  logic [STAT_W-1:0] status_r, status_next;
  logic [IDX_W-1:0]  found_r, found_next;
  logic              found_flag, found_flag_next;
  entry_t            rd_r, rd_next;
  logic              rsp_valid_next;
  rsp_t              rsp_next;
  logic              accept;
  logic              rsp_free;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign new_entry = key;

  always_comb begin
    state_next      = state;
    op_next         = op;
    pos_next        = pos;
    key_next        = key;
    count_next      = count;
    step_next       = step;
    status_next     = status_r;
    found_next      = found_r;
    found_flag_next = found_flag;
    rd_next         = rd_r;
    rsp_valid_next  = rsp_valid && !rsp_ready;
    rsp_next        = rsp;
    ctl.mode        = CELL_HOLD;
    ctl.lo          = '0;
    ctl.hi          = LAST;

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_next         = req.req_type;
          pos_next        = req.position;
          key_next        = '{req.singer_id, req.album_id, req.song_id};
          step_next       = '0;
          found_next      = '0;
          found_flag_next = 1'b0;
          rd_next         = '0;
          status_next     = ST_OK;
          state_next      = S_RUN;
          case (req.req_type)
            REQ_INSERT: begin
              if (count == CNT_W'(DEPTH)) begin
                status_next = ST_FULL;
                state_next  = S_FINISH;
              end else if (req.position > count) begin
                status_next = ST_BADPOS;
                state_next  = S_FINISH;
              end
            end
            REQ_DELETE, REQ_READ: begin
              if (req.position >= count) begin
                status_next = ST_BADPOS;
                state_next  = S_FINISH;
              end
            end
            REQ_SEARCH: begin
              status_next = ST_NOTFOUND;
            end
            REQ_REVERSE: begin
              step_next = IDX_W'(count - CNT_W'(1));
              if (count <= CNT_W'(1)) begin
                state_next = S_FINISH;
              end
            end
            default: begin
              status_next = ST_BADPOS;
              state_next  = S_FINISH;
            end
          endcase
        end
      end
      S_RUN: begin
        case (op)
          REQ_INSERT: begin
            ctl.mode   = CELL_SHR;
            ctl.lo     = pos[IDX_W-1:0];
            count_next = count + CNT_W'(1);
            state_next = S_FINISH;
          end
          REQ_DELETE: begin
            ctl.mode   = CELL_SHL;
            ctl.lo     = pos[IDX_W-1:0];
            count_next = count - CNT_W'(1);
            state_next = S_FINISH;
          end
          REQ_READ, REQ_SEARCH: begin
            // full rotation: head holds original entry 'step'
            ctl.mode  = CELL_SHL;
            step_next = step + IDX_W'(1);
            if (op == REQ_READ && CNT_W'(step) == pos) begin
              rd_next = head;
            end
            if (op == REQ_SEARCH && !found_flag && CNT_W'(step) < count &&
                head == key) begin
              found_flag_next = 1'b1;
              found_next      = step;
              status_next     = ST_OK;
            end
            if (step == LAST) begin
              state_next = S_FINISH;
            end
          end
          REQ_REVERSE: begin
            // move head to slot 'step', shifting slots below it down
            ctl.mode  = CELL_SHL;
            ctl.hi    = step;
            step_next = step - IDX_W'(1);
            if (step == IDX_W'(1)) begin
              state_next = S_FINISH;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_FINISH: begin
        if (rsp_free) begin
          rsp_valid_next       = 1'b1;
          rsp_next.status      = status_r;
          rsp_next.found_index = found_r;
          rsp_next.out_singer  = rd_r.singer;
          rsp_next.out_album   = rd_r.album;
          rsp_next.out_song    = rd_r.song;
          rsp_next.entry_count = count;
          state_next           = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    pos        <= pos_next;
    key        <= key_next;
    step       <= step_next;
    status_r   <= status_next;
    found_r    <= found_next;
    found_flag <= found_flag_next;
    rd_r       <= rd_next;
    rsp        <= rsp_next;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_count_only_in_run: assert property (@(posedge clk) disable iff (rst)
    state != S_RUN |=> count == $past(count))
    else $error("entry count changed outside an update");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_FINISH)
    else $error("result raised outside finish");

  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && op == REQ_SEARCH && status_r == ST_OK) |->
      CNT_W'(found_r) < count)
    else $error("search hit beyond used entries");

endmodule

[rtl/ordered_triple_list_engine_top.sv]
// ----------------------------------------------------------------------------
// ordered_triple_list_engine_top
// Ordered list of singer/album/song triples held in a chain of slot cells.
// ----------------------------------------------------------------------------
// One request at a time. Insert and delete make one parallel shift of the
// chain between accept and result. Read and search rotate the chain once
// through all DEPTH slots while slot 0 is inspected. Reverse makes one
// head-to-slot move for each used entry after the first, and none on a list
// of at most one entry. Rejected requests skip the chain entirely. A result
// waiting in the output register holds the sequencer in its finish state
// until it is taken.
module ordered_triple_list_engine_top
  import otle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  entry_t    cell_data [DEPTH];
  entry_t    new_entry;
  cell_ctl_t ctl;

  otle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .head      (cell_data[0]),
    .new_entry (new_entry),
    .ctl       (ctl)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_in;
    entry_t right_in;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_in = cell_data[0];
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end

    otle_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .ctl       (ctl),
      .left      (left_in),
      .right     (right_in),
      .head      (cell_data[0]),
      .new_entry (new_entry),
      .data      (cell_data[i])
    );
  end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for ordered_triple_list_engine_top.
// ----------------------------------------------------------------------------
// A directed table runs first. It covers the empty list, the ends of the
// list, rejected positions and unknown request types. Random traffic then
// fills the list to capacity, mixes all requests, and ends with a
// delete-heavy stretch. A shadow copy of the list predicts each result that
// the table does not give, and results are checked field by field in order.
// Both sides of the handshake idle at random. The receiver holds off once for a
// long stretch, and the sender once stops mid-traffic until the block is quiet.
// ----------------------------------------------------------------------------
module tb;
  import otle_pkg::*;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  entry_t      shadow_list [DEPTH];
  int unsigned shadow_len = 0;
  rsp_t        rsp_due_q [$];
  dir_row_t    dir_rows [$];

  int unsigned mismatches   = 0;
  int unsigned accepted     = 0;
  int unsigned checked      = 0;
  int unsigned peak_len     = 0;
  int unsigned full_rejects = 0;
  int unsigned search_hits  = 0;
  int unsigned burst_left   = 0;

  ordered_triple_list_engine_top uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rsp_t list_apply(req_t r);
    rsp_t   o;
    entry_t t;
    entry_t tmp;
    int unsigned pos;
    o = '0;
    o.status = ST_OK;
    pos = r.position;
    t.singer = r.singer_id;
    t.album  = r.album_id;
    t.song   = r.song_id;
    case (r.req_type)
      REQ_INSERT: begin
        if (shadow_len >= DEPTH) begin
          o.status = ST_FULL;
          full_rejects++;
        end else if (pos > shadow_len) begin
          o.status = ST_BADPOS;
        end else begin
          for (int j = shadow_len; j > pos; j--) shadow_list[j] = shadow_list[j-1];
          shadow_list[pos] = t;
          shadow_len++;
        end
      end
      REQ_DELETE: begin
        if (pos >= shadow_len) begin
          o.status = ST_BADPOS;
        end else begin
          for (int j = pos; j + 1 < shadow_len; j++) shadow_list[j] = shadow_list[j+1];
          shadow_len--;
        end
      end
      REQ_READ: begin
        if (pos >= shadow_len) begin
          o.status = ST_BADPOS;
        end else begin
          o.out_singer = shadow_list[pos].singer;
          o.out_album  = shadow_list[pos].album;
          o.out_song   = shadow_list[pos].song;
        end
      end
      REQ_SEARCH: begin
        o.status = ST_NOTFOUND;
        for (int j = 0; j < shadow_len; j++) begin
          if (shadow_list[j] == t) begin
            o.status = ST_OK;
            o.found_index = IDX_W'(j);
            search_hits++;
            break;
          end
        end
      end
      REQ_REVERSE: begin
        for (int j = 0; j < shadow_len / 2; j++) begin
          tmp = shadow_list[j];
          shadow_list[j] = shadow_list[shadow_len-1-j];
          shadow_list[shadow_len-1-j] = tmp;
        end
      end
      default: o.status = ST_BADPOS;
    endcase
    o.entry_count = CNT_W'(shadow_len);
    if (shadow_len > peak_len) peak_len = shadow_len;
    return o;
  endfunction

  function automatic req_t pick_request(mix_t mix);
    req_t r;
    entry_t e;
    int unsigned roll;
    int unsigned cut_ins, cut_del, cut_rd, cut_src, cut_rev;
    case (mix)
      MIX_FILL:     begin cut_ins = 78; cut_del = 83; cut_rd = 89; cut_src = 94; cut_rev = 97; end
      MIX_DRAIN:    begin cut_ins = 15; cut_del = 70; cut_rd = 80; cut_src = 90; cut_rev = 96; end
      default:      begin cut_ins = 30; cut_del = 50; cut_rd = 68; cut_src = 86; cut_rev = 96; end
    endcase
    r.req_type  = REQ_READ;
    r.position  = CNT_W'($urandom_range(0, 127));
    r.singer_id = ID_BITS'($urandom);
    r.album_id  = ID_BITS'($urandom);
    r.song_id   = ID_BITS'($urandom);
    e = '0;
    if (shadow_len > 0) e = shadow_list[$urandom_range(0, shadow_len - 1)];
    roll = $urandom_range(0, 99);
    if (roll < cut_ins) begin
      r.req_type = REQ_INSERT;
      roll = $urandom_range(0, 99);
      if (roll < 80) r.position = CNT_W'($urandom_range(0, shadow_len));
      else if (roll < 90) r.position = ($urandom_range(0, 1) != 0) ? CNT_W'(shadow_len) : '0;
      roll = $urandom_range(0, 99);
      if (shadow_len > 0 && roll < 20) begin
        r.singer_id = e.singer;
        r.album_id  = e.album;
        r.song_id   = e.song;
      end else if (roll < 30) begin
        r.singer_id = ID_BITS'($urandom_range(0, 3));
        r.album_id  = ID_BITS'($urandom_range(0, 3));
        r.song_id   = ID_BITS'($urandom_range(0, 3));
      end
    end else if (roll < cut_rd) begin
      r.req_type = (roll < cut_del) ? REQ_DELETE : REQ_READ;
      if (shadow_len > 0 && $urandom_range(0, 99) < 85)
        r.position = CNT_W'($urandom_range(0, shadow_len - 1));
    end else if (roll < cut_src) begin
      r.req_type = REQ_SEARCH;
      roll = $urandom_range(0, 99);
      if (shadow_len > 0 && roll < 75) begin
        r.singer_id = e.singer;
        r.album_id  = e.album;
        r.song_id   = e.song;
        if (roll >= 60) begin
          case ($urandom_range(0, 2))
            0:       r.singer_id ^= ID_BITS'(1) << $urandom_range(0, ID_BITS - 1);
            1:       r.album_id  ^= ID_BITS'(1) << $urandom_range(0, ID_BITS - 1);
            default: r.song_id   ^= ID_BITS'(1) << $urandom_range(0, ID_BITS - 1);
          endcase
        end
      end
    end else if (roll < cut_rev) begin
      r.req_type = REQ_REVERSE;
    end else begin
      r.req_type = TYPE_W'($urandom_range(5, 7));
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(8, 40);
    burst_left = 30;
    return 0;
  endfunction

  task automatic send_request(input req_t r, input bit typed = 1'b0, input rsp_t want = '0);
    rsp_t due;
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    due = list_apply(r);
    if (typed) due = want;
    rsp_due_q.push_back(due);
    accepted++;
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    req_valid <= 1'b0;
    @(negedge clk);
    while (rsp_due_q.size() != 0) @(negedge clk);
  endtask

  function automatic void add_row(req_t r, bit typed = 1'b0, rsp_t want = '0);
    dir_row_t row;
    row.r     = r;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (rsp_due_q.size() == 0) begin
        $display("%0t: result expected none got %h", $time, rsp);
        mismatches++;
      end else begin
        want = rsp_due_q.pop_front();
        check_field("status", want.status, rsp.status);
        check_field("found_index", want.found_index, rsp.found_index);
        check_field("out_singer", want.out_singer, rsp.out_singer);
        check_field("out_album", want.out_album, rsp.out_album);
        check_field("out_song", want.out_song, rsp.out_song);
        check_field("entry_count", want.entry_count, rsp.entry_count);
        checked++;
      end
    end
  end

  // receiver: random stalls, ready bursts, one long hold-off
  initial begin : rsp_sink
    int unsigned roll;
    bit held;
    held = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      roll = $urandom_range(0, 99);
      if (!held && checked >= 150) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else if (roll < 55) begin
        rsp_ready <= 1'b1;
        @(negedge clk);
      end else if (roll < 88) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else if (roll < 96) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(negedge clk);
      end else begin
        rsp_ready <= 1'b1;
        repeat (50) @(negedge clk);
      end
    end
  end

  initial begin : req_source
    mix_t mix;
    add_row('{REQ_READ,    7'd0,   16'h0,    16'h0,    16'h0   }, 1'b1,
            '{ST_BADPOS,   6'd0, 16'h0, 16'h0, 16'h0, 7'd0});
    add_row('{REQ_DELETE,  7'd0,   16'h0,    16'h0,    16'h0   }, 1'b1,
            '{ST_BADPOS,   6'd0, 16'h0, 16'h0, 16'h0, 7'd0});
    add_row('{REQ_SEARCH,  7'd0,   16'h0,    16'h0,    16'h0   }, 1'b1,
            '{ST_NOTFOUND, 6'd0, 16'h0, 16'h0, 16'h0, 7'd0});
    add_row('{REQ_REVERSE, 7'd0,   16'h0,    16'h0,    16'h0   }, 1'b1,
            '{ST_OK,       6'd0, 16'h0, 16'h0, 16'h0, 7'd0});
    add_row('{REQ_INSERT,  7'd1,   16'h1,    16'h2,    16'h3   }, 1'b1,
            '{ST_BADPOS,   6'd0, 16'h0, 16'h0, 16'h0, 7'd0});
    add_row('{REQ_INSERT,  7'd0,   16'hffff, 16'hffff, 16'hffff}, 1'b1,
            '{ST_OK,       6'd0, 16'h0, 16'h0, 16'h0, 7'd1});
    add_row('{REQ_REVERSE, 7'd0,   16'h0,    16'h0,    16'h0   }, 1'b1,
            '{ST_OK,       6'd0, 16'h0, 16'h0, 16'h0, 7'd1});
    add_row('{REQ_READ,    7'd0,   16'h0,    16'h0,    16'h0   }, 1'b1,
            '{ST_OK, 6'd0, 16'hffff, 16'hffff, 16'hffff, 7'd1});
    add_row('{REQ_INSERT,  7'd1,   16'h0,    16'h0,    16'h0   }, 1'b1,
            '{ST_OK,       6'd0, 16'h0, 16'h0, 16'h0, 7'd2});
    add_row('{REQ_INSERT,  7'd0,   16'h1234, 16'h5678, 16'h9abc}, 1'b1,
            '{ST_OK,       6'd0, 16'h0, 16'h0, 16'h0, 7'd3});
    add_row('{REQ_INSERT,  7'd2,   16'haaaa, 16'h5555, 16'haaaa}, 1'b1,
            '{ST_OK,       6'd0, 16'h0, 16'h0, 16'h0, 7'd4});
    add_row('{REQ_SEARCH,  7'd0,   16'h0,    16'h0,    16'h0   });
    add_row('{REQ_SEARCH,  7'd0,   16'hffff, 16'hffff, 16'h0   }, 1'b1,
            '{ST_NOTFOUND, 6'd0, 16'h0, 16'h0, 16'h0, 7'd4});
    add_row('{REQ_REVERSE, 7'd0,   16'h0,    16'h0,    16'h0   });
    add_row('{REQ_READ,    7'd3,   16'h0,    16'h0,    16'h0   });
    add_row('{REQ_SEARCH,  7'd0,   16'h1234, 16'h5678, 16'h9abc});
    add_row('{REQ_READ,    7'd4,   16'h0,    16'h0,    16'h0   }, 1'b1,
            '{ST_BADPOS,   6'd0, 16'h0, 16'h0, 16'h0, 7'd4});
    add_row('{REQ_READ,    7'd127, 16'h0,    16'h0,    16'h0   }, 1'b1,
            '{ST_BADPOS,   6'd0, 16'h0, 16'h0, 16'h0, 7'd4});
    add_row('{REQ_DELETE,  7'd127, 16'h0,    16'h0,    16'h0   }, 1'b1,
            '{ST_BADPOS,   6'd0, 16'h0, 16'h0, 16'h0, 7'd4});
    add_row('{REQ_INSERT,  7'd64,  16'h0,    16'h0,    16'h0   }, 1'b1,
            '{ST_BADPOS,   6'd0, 16'h0, 16'h0, 16'h0, 7'd4});
    add_row('{3'd5,        7'd0,   16'h0,    16'h0,    16'h0   }, 1'b1,
            '{ST_BADPOS,   6'd0, 16'h0, 16'h0, 16'h0, 7'd4});
    add_row('{3'd6,        7'd1,   16'h0,    16'h0,    16'h0   }, 1'b1,
            '{ST_BADPOS,   6'd0, 16'h0, 16'h0, 16'h0, 7'd4});
    add_row('{3'd7,        7'd2,   16'h0,    16'h0,    16'h0   }, 1'b1,
            '{ST_BADPOS,   6'd0, 16'h0, 16'h0, 16'h0, 7'd4});
    add_row('{REQ_DELETE,  7'd0,   16'h0,    16'h0,    16'h0   });
    add_row('{REQ_DELETE,  7'd2,   16'h0,    16'h0,    16'h0   });

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) send_request(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want);
    wait_quiet();

    for (int n = 0; n < 430; n++) begin
      if (n < 150) mix = MIX_FILL;
      else if (n < 330) mix = MIX_BALANCED;
      else mix = MIX_DRAIN;
      if (n == 230) wait_quiet();
      send_request(pick_request(mix));
    end

    wait_quiet();
    repeat (DEPTH + 8) @(negedge clk);
    $display("covered %0d requests, %0d results checked", accepted, checked);
    $display("list peaked at %0d entries; %0d full rejects, %0d search hits",
             peak_len, full_rejects, search_hits);
    if (mismatches == 0) begin
      $display("ordered_triple_list_engine_top regression: pass");
    end else begin
      $display("ordered_triple_list_engine_top regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("ordered_triple_list_engine_top regression: fail");
    $finish;
  end

endmodule
